@@ hdl/fip_pkg.sv @@
// Package for the frame interval profiler: payload structs, codes, constants.
// No dependencies; used by every module under hdl.
`default_nettype none
package fip_pkg;
    localparam int WindowFramesDefault = 128;
    localparam logic [31:0] LimitFastReset = 32'd17000000;
    localparam logic [31:0] LimitMidReset  = 32'd33000000;
    localparam logic [31:0] LimitLowReset  = 32'd50000000;
    localparam logic [31:0] LimitSlowReset = 32'd100000000;

    localparam logic [1:0] CfgFast = 2'd0;
    localparam logic [1:0] CfgMid  = 2'd1;
    localparam logic [1:0] CfgLow  = 2'd2;
    localparam logic [1:0] CfgSlow = 2'd3;

    localparam logic [1:0] KindNone    = 2'd0;
    localparam logic [1:0] KindWindow  = 2'd1;
    localparam logic [1:0] KindSession = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic        present_ok;
        logic [63:0] time_ns;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  report_kind;
        logic [31:0] frame_count;
        logic [63:0] avg_interval;
        logic [63:0] peak_interval;
        logic [31:0] failure_count;
        logic [31:0] count_fast;
        logic [31:0] count_mid;
        logic [31:0] count_low;
        logic [31:0] count_slow;
        logic [31:0] count_idle;
    } out_item_t;

    // Report waiting for its mean: sum and divisor travel with it.
    typedef struct packed {
        out_item_t   rep;
        logic [63:0] sum;
        logic [31:0] samples;
    } job_t;

    typedef enum logic [1:0] { DIV_IDLE, DIV_RUN, DIV_DONE } div_state_t;
endpackage
`default_nettype wire

@@ hdl/fip_front.sv @@
// Front part: accumulates window and session statistics, builds reports.
// Depends on fip_pkg.
`default_nettype none
module fip_front
    import fip_pkg::*;
#(
    parameter int WINDOW_FRAMES = WindowFramesDefault
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    input  wire in_item_t    item,
    output logic             item_ready,
    input  wire logic [31:0] limit_fast,
    input  wire logic [31:0] limit_mid,
    input  wire logic [31:0] limit_low,
    input  wire logic [31:0] limit_slow,
    output logic             job_valid,
    output job_t             job,
    input  wire logic        job_ready
);
    localparam int NB = 5;

    logic [63:0] last_time_reg, last_time_next;
    logic        have_last_reg, have_last_next;
    logic [63:0] win_sum_reg, win_sum_next, win_max_reg, win_max_next;
    logic [12:0] win_frames_reg, win_frames_next;
    logic [31:0] win_fail_reg, win_fail_next;
    logic [12:0] win_b_reg [NB];
    logic [12:0] win_b_next [NB];
    logic [63:0] ses_sum_reg, ses_sum_next, ses_max_reg, ses_max_next;
    logic [31:0] ses_frames_reg, ses_frames_next, ses_fail_reg, ses_fail_next;
    logic [31:0] ses_b_reg [NB];
    logic [31:0] ses_b_next [NB];

    logic [63:0] dt;
    logic [2:0]  bkt;
    logic        fire;
    logic [12:0] wf_inc;
    logic [63:0] ws_new, wm_new;
    logic [12:0] wb_new [NB];
    job_t        job_c;
    logic        job_emit;

    assign item_ready = job_ready;
    assign fire = item_valid && item_ready;
    assign dt = item.time_ns - last_time_reg;

    // Bucket select: first limit at or above the interval
    always_comb
    begin
        if (dt <= {32'd0, limit_fast})      bkt = 3'd0;
        else if (dt <= {32'd0, limit_mid})  bkt = 3'd1;
        else if (dt <= {32'd0, limit_low})  bkt = 3'd2;
        else if (dt <= {32'd0, limit_slow}) bkt = 3'd3;
        else                                bkt = 3'd4;
    end

    // State update and report build
    always_comb
    begin
        last_time_next  = last_time_reg;
        have_last_next  = have_last_reg;
        win_sum_next    = win_sum_reg;
        win_max_next    = win_max_reg;
        win_frames_next = win_frames_reg;
        win_fail_next   = win_fail_reg;
        ses_sum_next    = ses_sum_reg;
        ses_max_next    = ses_max_reg;
        ses_frames_next = ses_frames_reg;
        ses_fail_next   = ses_fail_reg;
        ws_new = win_sum_reg;
        wm_new = win_max_reg;
        wf_inc = win_frames_reg + 13'd1;
        for (int i = 0; i < NB; i++)
        begin
            win_b_next[i] = win_b_reg[i];
            ses_b_next[i] = ses_b_reg[i];
            wb_new[i]     = win_b_reg[i];
        end
        job_c    = '0;
        job_emit = 1'b0;
        if (have_last_reg)
        begin
            ws_new = win_sum_reg + dt;
            wm_new = (dt > win_max_reg) ? dt : win_max_reg;
            for (int i = 0; i < NB; i++)
                if (bkt == 3'(i))
                    wb_new[i] = win_b_reg[i] + 13'd1;
        end
        if (item.req_type)
        begin
            job_c.rep.frame_count   = ses_frames_reg + {19'd0, win_frames_reg};
            job_c.sum               = ses_sum_reg + win_sum_reg;
            job_c.rep.peak_interval = (win_max_reg > ses_max_reg) ? win_max_reg : ses_max_reg;
            job_c.rep.failure_count = ses_fail_reg + win_fail_reg;
            job_c.rep.count_fast    = ses_b_reg[0] + {19'd0, win_b_reg[0]};
            job_c.rep.count_mid     = ses_b_reg[1] + {19'd0, win_b_reg[1]};
            job_c.rep.count_low     = ses_b_reg[2] + {19'd0, win_b_reg[2]};
            job_c.rep.count_slow    = ses_b_reg[3] + {19'd0, win_b_reg[3]};
            job_c.rep.count_idle    = ses_b_reg[4] + {19'd0, win_b_reg[4]};
            if (job_c.rep.frame_count != 32'd0)
                job_c.rep.report_kind = KindSession;
            else
                job_c = '0;
        end
        else if (!item.present_ok)
        begin
            win_fail_next = win_fail_reg + 32'd1;
        end
        else
        begin
            last_time_next = item.time_ns;
            have_last_next = 1'b1;
            if (wf_inc >= 13'(WINDOW_FRAMES))
            begin
                job_c.rep.report_kind   = KindWindow;
                job_c.rep.frame_count   = {19'd0, wf_inc};
                job_c.sum               = ws_new;
                job_c.rep.peak_interval = wm_new;
                job_c.rep.failure_count = win_fail_reg;
                job_c.rep.count_fast    = {19'd0, wb_new[0]};
                job_c.rep.count_mid     = {19'd0, wb_new[1]};
                job_c.rep.count_low     = {19'd0, wb_new[2]};
                job_c.rep.count_slow    = {19'd0, wb_new[3]};
                job_c.rep.count_idle    = {19'd0, wb_new[4]};
                ses_sum_next    = ses_sum_reg + ws_new;
                ses_max_next    = (wm_new > ses_max_reg) ? wm_new : ses_max_reg;
                ses_frames_next = ses_frames_reg + {19'd0, wf_inc};
                ses_fail_next   = ses_fail_reg + win_fail_reg;
                for (int i = 0; i < NB; i++)
                begin
                    ses_b_next[i] = ses_b_reg[i] + {19'd0, wb_new[i]};
                    win_b_next[i] = '0;
                end
                win_sum_next    = '0;
                win_max_next    = '0;
                win_frames_next = '0;
                win_fail_next   = '0;
            end
            else
            begin
                win_sum_next    = ws_new;
                win_max_next    = wm_new;
                win_frames_next = wf_inc;
                for (int i = 0; i < NB; i++)
                    win_b_next[i] = wb_new[i];
            end
        end
        // samples = frames-1 when sum is nonzero
        job_c.samples = (job_c.sum != 64'd0) ? job_c.rep.frame_count - 32'd1
                                             : job_c.rep.frame_count;
        job_emit = 1'b1;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg  <= '0;
            have_last_reg  <= 1'b0;
            win_sum_reg    <= '0;
            win_max_reg    <= '0;
            win_frames_reg <= '0;
            win_fail_reg   <= '0;
            ses_sum_reg    <= '0;
            ses_max_reg    <= '0;
            ses_frames_reg <= '0;
            ses_fail_reg   <= '0;
            for (int i = 0; i < NB; i++)
            begin
                win_b_reg[i] <= '0;
                ses_b_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            last_time_reg  <= last_time_next;
            have_last_reg  <= have_last_next;
            win_sum_reg    <= win_sum_next;
            win_max_reg    <= win_max_next;
            win_frames_reg <= win_frames_next;
            win_fail_reg   <= win_fail_next;
            ses_sum_reg    <= ses_sum_next;
            ses_max_reg    <= ses_max_next;
            ses_frames_reg <= ses_frames_next;
            ses_fail_reg   <= ses_fail_next;
            for (int i = 0; i < NB; i++)
            begin
                win_b_reg[i] <= win_b_next[i];
                ses_b_reg[i] <= ses_b_next[i];
            end
        end
    end

    // Every item yields one job toward the back part
    assign job_valid = fire && job_emit;
    assign job = job_c;

    // Window frame count never reaches the window size between items
    a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
        win_frames_reg < 13'(WINDOW_FRAMES))
        else $error("window frame count overflow");
    a_have_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.req_type && item.present_ok |=> have_last_reg)
        else $error("have_last not set after present");
    a_summary_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.req_type |=> $stable(win_frames_reg) && $stable(ses_frames_reg))
        else $error("summary changed state");
endmodule
`default_nettype wire

@@ hdl/fip_queue.sv @@
// Short job queue between front and back parts.
// Depends on fip_pkg.
`default_nettype none
module fip_queue
    import fip_pkg::*;
#(
    parameter int DEPTH = 2
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    input  wire job_t wr_data,
    output logic      wr_ready,
    output logic      rd_valid,
    output job_t      rd_data,
    input  wire logic rd_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    job_t            mem_reg [DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;
    logic            wr_fire, rd_fire;

    assign wr_ready = cnt_reg != (AW+1)'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;
    assign rd_data  = mem_reg[rp_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (wr_fire)
            mem_reg[wp_reg] <= wr_data;
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_fire)
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + AW'(1);
            if (rd_fire)
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        wr_fire && !rd_fire |=> cnt_reg == $past(cnt_reg) + (AW+1)'(1))
        else $error("queue count mismatch");
    a_rd: assert property (@(posedge clk) disable iff (!rst_n)
        rd_fire && !wr_fire |=> cnt_reg == $past(cnt_reg) - (AW+1)'(1))
        else $error("queue count mismatch");
endmodule
`default_nettype wire

@@ hdl/fip_back.sv @@
// Back part: radix-2 restoring divide for the mean, then output register.
// Depends on fip_pkg.
`default_nettype none
module fip_back
    import fip_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_ready,
    output logic      empty,
    output out_item_t result,
    input  wire logic pop
);
    div_state_t  state_reg, state_next;
    out_item_t   rep_reg;
    logic [63:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [5:0]  step_reg;
    logic [32:0] trial;
    logic        take;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (job_valid) state_next = DIV_RUN;
            DIV_RUN:  if (step_reg == 6'd63) state_next = DIV_DONE;
            DIV_DONE: if (pop) state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        job_ready = 1'b0;
        empty     = 1'b1;
        case (state_reg)
            DIV_IDLE: job_ready = 1'b1;
            DIV_DONE: empty = 1'b0;
            default:  ;
        endcase
    end

    // One quotient bit per cycle
    assign trial = {rem_reg[31:0], quo_reg[63]};
    assign take  = trial >= {1'b0, den_reg};
    assign rem_next = take ? trial - {1'b0, den_reg} : trial;
    assign quo_next = {quo_reg[62:0], take};

    always_comb
    begin
        result = rep_reg;
        result.avg_interval = (den_reg == 32'd0) ? 64'd0 : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == DIV_RUN)
                step_reg <= step_reg + 6'd1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && job_valid)
        begin
            rep_reg <= job.rep;
            quo_reg <= job.sum;
            rem_reg <= '0;
            den_reg <= job.samples;
        end
        else if (state_reg == DIV_RUN)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN && step_reg == 6'd63 |=> state_reg == DIV_DONE)
        else $error("divide length wrong");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_DONE && !pop |=> state_reg == DIV_DONE)
        else $error("result dropped");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == DIV_RUN |-> rem_reg < {1'b0, den_reg} || den_reg == 32'd0)
        else $error("remainder out of range");
endmodule
`default_nettype wire

@@ hdl/frame_interval_profiler.sv @@
// Frame interval profiler top: config registers, front, queue, back.
// The mean comes from a 64-step divide in the back part.
// The bit-serial divider takes one job at a time; the two-entry queue lets
// the front take items while a divide runs, until the queue is full.
// Reset: asynchronous, active low; clears all statistics and loads the limits.
// Depends on fip_pkg, fip_front, fip_queue, fip_back.
`default_nettype none
module frame_interval_profiler
    import fip_pkg::*;
#(
    parameter int WINDOW_FRAMES = WindowFramesDefault
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    in_item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        out_item,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [31:0] lim_fast_reg, lim_mid_reg, lim_low_reg, lim_slow_reg;
    logic        f_ready, j_valid, j_ready, b_valid, b_ready;
    job_t        j_data, b_data;

    assign cfg_ready = 1'b1;
    assign full = !f_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_fast_reg <= LimitFastReset;
            lim_mid_reg  <= LimitMidReset;
            lim_low_reg  <= LimitLowReset;
            lim_slow_reg <= LimitSlowReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CfgFast: lim_fast_reg <= cfg_data;
                CfgMid:  lim_mid_reg  <= cfg_data;
                CfgLow:  lim_low_reg  <= cfg_data;
                CfgSlow: lim_slow_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    fip_front #(.WINDOW_FRAMES(WINDOW_FRAMES)) u_front (
        .clk, .rst_n,
        .item_valid(push), .item(in_item), .item_ready(f_ready),
        .limit_fast(lim_fast_reg), .limit_mid(lim_mid_reg),
        .limit_low(lim_low_reg), .limit_slow(lim_slow_reg),
        .job_valid(j_valid), .job(j_data), .job_ready(j_ready)
    );

    fip_queue #(.DEPTH(2)) u_queue (
        .clk, .rst_n,
        .wr_valid(j_valid), .wr_data(j_data), .wr_ready(j_ready),
        .rd_valid(b_valid), .rd_data(b_data), .rd_ready(b_ready)
    );

    fip_back u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job(b_data), .job_ready(b_ready),
        .empty, .result(out_item), .pop
    );
endmodule
`default_nettype wire

@@ sim/fip_checker.sv @@
// Checker for the frame interval profiler: watches the input, config and result
// channels, keeps its own copy of the window and session statistics, compares.
// Depends on fip_pkg.
module fip_checker
    import fip_pkg::*;
#(
    parameter int WINDOW_FRAMES = WindowFramesDefault
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire logic        full,
    input  wire in_item_t    in_item,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire out_item_t   out_item,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               report_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Limits and statistics
    logic [31:0] lim_fast, lim_mid, lim_low, lim_slow;
    logic [63:0] prev_time;
    logic        prev_valid;
    logic [63:0] w_sum, w_max, s_sum, s_max;
    logic [12:0] w_frames;
    logic [31:0] w_fails, s_frames, s_fails;
    logic [12:0] w_bins [5];
    logic [31:0] s_bins [5];

    out_item_t expected_reports [$];

    function automatic logic [63:0] avg_of(logic [63:0] sum, logic [31:0] frames);
        logic [31:0] samples;
        samples = (sum != 0) ? frames - 32'd1 : frames;
        return (samples != 0) ? sum / {32'd0, samples} : 64'd0;
    endfunction

    function automatic int bin_of(logic [63:0] dt);
        if (dt <= {32'd0, lim_fast}) return 0;
        if (dt <= {32'd0, lim_mid}) return 1;
        if (dt <= {32'd0, lim_low}) return 2;
        if (dt <= {32'd0, lim_slow}) return 3;
        return 4;
    endfunction

    // Apply one accepted item and return the report it produces
    task automatic profile_item(input in_item_t it, output out_item_t rep);
        logic [31:0] fr, fl;
        logic [31:0] b [5];
        logic [63:0] dt;
        int          k;
        rep = '0;
        if (it.req_type)
        begin
            fr = s_frames + {19'd0, w_frames};
            fl = s_fails + w_fails;
            for (k = 0; k < 5; k++) b[k] = s_bins[k] + {19'd0, w_bins[k]};
            if (fr != 0)
            begin
                rep.report_kind   = KindSession;
                rep.frame_count   = fr;
                rep.avg_interval  = avg_of(s_sum + w_sum, fr);
                rep.peak_interval = (w_max > s_max) ? w_max : s_max;
                rep.failure_count = fl;
                {rep.count_fast, rep.count_mid, rep.count_low, rep.count_slow,
                    rep.count_idle} = {b[0], b[1], b[2], b[3], b[4]};
            end
        end
        else if (!it.present_ok)
        begin
            w_fails++;
        end
        else
        begin
            if (prev_valid)
            begin
                dt = it.time_ns - prev_time;
                w_sum += dt;
                if (dt > w_max) w_max = dt;
                w_bins[bin_of(dt)]++;
            end
            prev_time  = it.time_ns;
            prev_valid = 1'b1;
            w_frames++;
            if (w_frames >= WINDOW_FRAMES)
            begin
                rep.report_kind   = KindWindow;
                rep.frame_count   = {19'd0, w_frames};
                rep.avg_interval  = avg_of(w_sum, {19'd0, w_frames});
                rep.peak_interval = w_max;
                rep.failure_count = w_fails;
                {rep.count_fast, rep.count_mid, rep.count_low, rep.count_slow,
                    rep.count_idle} = {19'd0, w_bins[0], 19'd0, w_bins[1],
                    19'd0, w_bins[2], 19'd0, w_bins[3], 19'd0, w_bins[4]};
                s_sum += w_sum;
                if (w_max > s_max) s_max = w_max;
                s_frames += {19'd0, w_frames};
                s_fails  += w_fails;
                for (k = 0; k < 5; k++) s_bins[k] += {19'd0, w_bins[k]};
                w_sum = 0; w_max = 0; w_frames = 0; w_fails = 0;
                for (k = 0; k < 5; k++) w_bins[k] = 0;
            end
        end
    endtask

    // Track the channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t rep, exp_rep;
        if (!rst_n)
        begin
            lim_fast = LimitFastReset; lim_mid = LimitMidReset;
            lim_low = LimitLowReset;   lim_slow = LimitSlowReset;
            prev_time = 0; prev_valid = 0;
            w_sum = 0; w_max = 0; w_frames = 0; w_fails = 0;
            s_sum = 0; s_max = 0; s_frames = 0; s_fails = 0;
            for (int k = 0; k < 5; k++)
            begin
                w_bins[k] = 0;
                s_bins[k] = 0;
            end
            expected_reports.delete();
            fail_count <= 0;
            report_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CfgFast: lim_fast = cfg_data;
                    CfgMid:  lim_mid  = cfg_data;
                    CfgLow:  lim_low  = cfg_data;
                    CfgSlow: lim_slow = cfg_data;
                    default: ;
                endcase
            end
            if (push && !full)
            begin
                profile_item(in_item, rep);
                expected_reports.push_back(rep);
            end
            if (pop && !empty)
            begin
                report_count <= report_count + 1;
                if (expected_reports.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected report %p", $realtime, out_item);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_rep = expected_reports.pop_front();
                    if (out_item !== exp_rep)
                    begin
                        if (fail_count < 10)
                            $display("%0t: report mismatch\n  exp %p\n  got %p",
                                $realtime, exp_rep, out_item);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_reports.size();
        end
    end
endmodule

@@ sim/tb_frame_interval_profiler.sv @@
// Testbench top for the frame interval profiler: clock, reset, stimulus and verdict.
// Depends on fip_pkg, frame_interval_profiler and fip_checker.
module tb_frame_interval_profiler;
    import fip_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW = 128;
    localparam int N_RANDOM = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int          fail_count, pending, report_count;
    logic [63:0] clock_ns = 64'd1000;
    int          burst_left = 0;
    int          item_count = 0;

    frame_interval_profiler #(.WINDOW_FRAMES(WINDOW)) dut (.*);

    fip_checker #(.WINDOW_FRAMES(WINDOW)) checker_i (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side stalls in its own on/off pattern
    initial
    begin
        int phase;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if ((phase / 200) % 3 == 0) pop <= 1'b1;
            else pop <= ($urandom_range(0, 3) != 0);
        end
    end

    // Push one item; push stays high inside a burst and drops for the gap
    task automatic send_item(input in_item_t it);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_item <= it;
        push <= 1'b1;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        item_count++;
    endtask

    task automatic send_present(input logic ok, input logic [63:0] t);
        in_item_t it;
        it.req_type = 1'b0;
        it.present_ok = ok;
        it.time_ns = t;
        send_item(it);
    endtask

    task automatic send_summary();
        in_item_t it;
        it.req_type = 1'b1;
        it.present_ok = 1'($urandom_range(0, 1));
        it.time_ns = {$urandom, $urandom};
        send_item(it);
    endtask

    // Valid stays high across consecutive writes; set_limits drops it
    task automatic write_limit(input logic [1:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Stop pushing, wait for every expected report, then the block's latency
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (150) @(negedge clk);
    endtask

    task automatic set_limits(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input logic [31:0] d);
        drain();
        write_limit(CfgFast, a);
        write_limit(CfgMid, b);
        write_limit(CfgLow, c);
        write_limit(CfgSlow, d);
        cfg_valid <= 1'b0;
    endtask

    // Random successful/failed presents and summaries, mostly plausible frame steps
    task automatic random_phase(input int n);
        logic [63:0] step;
        int          r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4) send_summary();
            else if (r < 10) send_present(1'b0, {$urandom, $urandom});
            else
            begin
                case ($urandom_range(0, 9))
                    0: step = {$urandom, $urandom};
                    1: step = 64'($urandom_range(0, 3));
                    2: step = {32'd0, $urandom};
                    default: step = 64'($urandom_range(5000000, 120000000));
                endcase
                clock_ns += step;
                send_present(1'b1, clock_ns);
            end
        end
    endtask

    initial
    begin
        #3000000;
        $display("** frame_interval_profiler: FAILED **");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Directed: empty summary, first present, zero time, backward time, extremes
        send_summary();
        send_present(1'b0, 64'd0);
        send_summary();
        send_present(1'b1, 64'd0);
        send_present(1'b1, 64'd0);
        send_present(1'b1, 64'd17000000);
        send_present(1'b1, 64'd50000001);
        send_present(1'b1, 64'd10);
        send_present(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_present(1'b1, 64'd5);
        send_present(1'b1, 64'h8000_0000_0000_0000);
        send_present(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_summary();
        clock_ns = 64'h8000_0000_0000_0000;

        // Unordered and extreme limits, then random limits, then the reset limits
        set_limits(32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFF);
        random_phase(N_RANDOM / 4);
        set_limits(32'd0, 32'd0, 32'd0, 32'd0);
        send_present(1'b1, clock_ns);
        send_present(1'b1, clock_ns + 64'd1);
        send_summary();
        random_phase(N_RANDOM / 4);
        set_limits($urandom, $urandom, $urandom, $urandom);
        random_phase(N_RANDOM / 4);
        set_limits(LimitFastReset, LimitMidReset, LimitLowReset, LimitSlowReset);
        random_phase(N_RANDOM / 4);
        send_summary();

        drain();
        $display("Sent %0d items (presents, failures, summaries) over four limit settings;",
            item_count);
        $display("checked %0d reports, %0d mismatches.", report_count, fail_count);
        if (fail_count == 0)
            $display("** frame_interval_profiler: PASSED **");
        else
            $display("** frame_interval_profiler: FAILED **");
        $finish;
    end
endmodule
